// ===== rtl/fec_xor_repair_accumulator_top_macros.svh =====
// assertion macros for the xor repair accumulator
`ifndef FEC_XOR_REPAIR_ACCUMULATOR_TOP_MACROS_SVH
`define FEC_XOR_REPAIR_ACCUMULATOR_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define FXRA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fxra assertion failed");

// next-cycle implication, checked out of reset
`define FXRA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fxra assertion failed");

`endif

// ===== rtl/fxra_pkg.sv =====
// types and constants shared by the xor repair accumulator
`timescale 1ns / 1ps
package fxra_pkg;

  localparam int MAX_PAYLOAD_DEF = 2048;
  localparam int FUNC_W  = 2;
  localparam int SEQ_W   = 16;
  localparam int TS_W    = 32;
  localparam int LEN_W   = 12;
  localparam int IDX_W   = 11;
  localparam int BYTE_W  = 8;
  localparam int HDR_W   = 16;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'd1;
  localparam logic [CFG_W-1:0]     CFG_RESET   = 8'd1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_RESTART = 2'd0,
    FUNC_HEADER  = 2'd1,
    FUNC_ADD     = 2'd2,
    FUNC_READ    = 2'd3
  } func_t;

  typedef struct packed {
    func_t              func;
    logic [SEQ_W-1:0]   seqnum_base;
    logic [1:0]         version;
    logic               pad_bit;
    logic               ext_bit;
    logic [3:0]         csrc_count;
    logic               marker;
    logic [6:0]         payload_type;
    logic [TS_W-1:0]    timestamp;
    logic [LEN_W-1:0]   payload_length;
    logic [IDX_W-1:0]   byte_index;
    logic [BYTE_W-1:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic               we;
    logic               xor_en;
    logic               rd_zero;
  } dec_t;

  typedef struct packed {
    logic [HDR_W-1:0]   header_xor;
    logic [TS_W-1:0]    timestamp_xor;
    logic [LEN_W-1:0]   length_xor;
    logic [SEQ_W-1:0]   base_out;
    logic [CFG_W-1:0]   columns_out;
    logic [CFG_W-1:0]   rows_out;
    logic [LEN_W-1:0]   repair_length;
  } snap_t;

endpackage

// ===== rtl/fxra_in_if.sv =====
// input item channel
`timescale 1ns / 1ps
interface fxra_in_if;
  import fxra_pkg::*;

  logic               valid;
  logic               ready;
  func_t              func;
  logic [SEQ_W-1:0]   seqnum_base;
  logic [1:0]         version;
  logic               pad_bit;
  logic               ext_bit;
  logic [3:0]         csrc_count;
  logic               marker;
  logic [6:0]         payload_type;
  logic [TS_W-1:0]    timestamp;
  logic [LEN_W-1:0]   payload_length;
  logic [IDX_W-1:0]   byte_index;
  logic [BYTE_W-1:0]  data_byte;

  modport source (
    output valid, func, seqnum_base, version, pad_bit, ext_bit, csrc_count,
           marker, payload_type, timestamp, payload_length, byte_index, data_byte,
    input  ready
  );
  modport sink (
    input  valid, func, seqnum_base, version, pad_bit, ext_bit, csrc_count,
           marker, payload_type, timestamp, payload_length, byte_index, data_byte,
    output ready
  );
endinterface

// ===== rtl/fxra_out_if.sv =====
// result channel
`timescale 1ns / 1ps
interface fxra_out_if;
  import fxra_pkg::*;

  logic               valid;
  logic               ready;
  logic [HDR_W-1:0]   header_xor;
  logic [TS_W-1:0]    timestamp_xor;
  logic [LEN_W-1:0]   length_xor;
  logic [SEQ_W-1:0]   base_out;
  logic [CFG_W-1:0]   columns_out;
  logic [CFG_W-1:0]   rows_out;
  logic [LEN_W-1:0]   repair_length;
  logic [BYTE_W-1:0]  repair_byte;

  modport source (
    output valid, header_xor, timestamp_xor, length_xor, base_out, columns_out,
           rows_out, repair_length, repair_byte,
    input  ready
  );
  modport sink (
    input  valid, header_xor, timestamp_xor, length_xor, base_out, columns_out,
           rows_out, repair_length, repair_byte,
    output ready
  );
endinterface

// ===== rtl/fxra_ram.sv =====
// repair payload store, one write and one registered read port
`timescale 1ns / 1ps
module fxra_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata_r
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== rtl/fxra_state.sv =====
// accumulators, length tracking, config registers and per-item store decisions
`timescale 1ns / 1ps
module fxra_state #(
  parameter int MAX_PAYLOAD = fxra_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fxra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fxra_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          accept,
  input  fxra_pkg::item_t               item,
  output fxra_pkg::dec_t                dec,
  output fxra_pkg::snap_t               snap
);
  import fxra_pkg::*;

  localparam int CW = 17;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_PAYLOAD);

  logic [HDR_W-1:0] header_acc_r, header_acc_nxt;
  logic [TS_W-1:0]  timestamp_acc_r, timestamp_acc_nxt;
  logic [LEN_W-1:0] length_acc_r, length_acc_nxt;
  logic [SEQ_W-1:0] base_r, base_nxt;
  logic [LEN_W-1:0] repair_len_r, repair_len_nxt;
  logic [LEN_W-1:0] prior_len_r, prior_len_nxt;
  logic [LEN_W-1:0] source_len_r, source_len_nxt;
  logic [CFG_W-1:0] columns_r, rows_r;

  logic [HDR_W-1:0] hdr_word;
  logic [LEN_W-1:0] len_sat;
  logic [LEN_W:0]   idx_ext;
  logic             idx_in_store;

  assign hdr_word = {item.marker, item.payload_type,
                     item.version, item.pad_bit, item.ext_bit, item.csrc_count};
  assign len_sat  = ({{(CW-LEN_W){1'b0}}, item.payload_length} > MAX_C) ?
                    LEN_W'(MAX_PAYLOAD) : item.payload_length;
  assign idx_ext  = {2'b00, item.byte_index};
  assign idx_in_store = {{(CW-IDX_W){1'b0}}, item.byte_index} < MAX_C;

  always_comb begin
    header_acc_nxt    = header_acc_r;
    timestamp_acc_nxt = timestamp_acc_r;
    length_acc_nxt    = length_acc_r;
    base_nxt          = base_r;
    repair_len_nxt    = repair_len_r;
    prior_len_nxt     = prior_len_r;
    source_len_nxt    = source_len_r;
    dec               = '0;
    case (item.func)
      FUNC_RESTART: begin
        header_acc_nxt    = '0;
        timestamp_acc_nxt = '0;
        length_acc_nxt    = '0;
        base_nxt          = item.seqnum_base;
        repair_len_nxt    = '0;
        prior_len_nxt     = '0;
        source_len_nxt    = '0;
      end
      FUNC_HEADER: begin
        header_acc_nxt    = header_acc_r ^ hdr_word;
        timestamp_acc_nxt = timestamp_acc_r ^ item.timestamp;
        length_acc_nxt    = length_acc_r ^ item.payload_length;
        prior_len_nxt     = repair_len_r;
        source_len_nxt    = len_sat;
        if (len_sat > repair_len_r) begin
          repair_len_nxt = len_sat;
        end
      end
      FUNC_ADD: begin
        dec.we     = (idx_ext < {1'b0, source_len_r}) && idx_in_store;
        dec.xor_en = idx_ext < {1'b0, prior_len_r};
      end
      FUNC_READ: begin
        dec.rd_zero = !((idx_ext < {1'b0, repair_len_r}) && idx_in_store);
      end
      default: begin
        dec = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_acc_r    <= '0;
      timestamp_acc_r <= '0;
      length_acc_r    <= '0;
      base_r          <= '0;
      repair_len_r    <= '0;
      prior_len_r     <= '0;
      source_len_r    <= '0;
    end else if (accept) begin
      header_acc_r    <= header_acc_nxt;
      timestamp_acc_r <= timestamp_acc_nxt;
      length_acc_r    <= length_acc_nxt;
      base_r          <= base_nxt;
      repair_len_r    <= repair_len_nxt;
      prior_len_r     <= prior_len_nxt;
      source_len_r    <= source_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= CFG_RESET;
      rows_r    <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLUMNS: columns_r <= cfg_data;
        CFG_ROWS:    rows_r    <= cfg_data;
        default:     columns_r <= columns_r;
      endcase
    end
  end

  assign snap.header_xor    = header_acc_r;
  assign snap.timestamp_xor = timestamp_acc_r;
  assign snap.length_xor    = length_acc_r;
  assign snap.base_out      = base_r;
  assign snap.columns_out   = columns_r;
  assign snap.rows_out      = rows_r;
  assign snap.repair_length = repair_len_r;

endmodule

// ===== rtl/fec_xor_repair_accumulator_top.sv =====
// top level of the xor parity repair accumulator
// one transaction per cycle unless out_ch stalls a read; reads pass s1 and out_snap_r
// payload byte adds do a read-modify-write of the store via s1 with forwarding
// one store read port sets throughput: one transaction per cycle barring out_ch stalls
// synchronous active-low reset clears control and accumulators; store is not cleared
`timescale 1ns / 1ps
module fec_xor_repair_accumulator_top #(
  parameter int MAX_PAYLOAD = fxra_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fxra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fxra_pkg::CFG_W-1:0]     cfg_data,
  fxra_in_if.sink                        in_ch,
  fxra_out_if.source                     out_ch
);
  import fxra_pkg::*;

  `include "fec_xor_repair_accumulator_top_macros.svh"

  localparam int DEPTH = (MAX_PAYLOAD < (1 << IDX_W)) ? MAX_PAYLOAD : (1 << IDX_W);
  localparam int AW    = $clog2(DEPTH);

  item_t item;
  dec_t  dec;
  snap_t snap;
  logic  accept;
  logic  in_ready;
  logic  s1_adv;
  logic  need_s1;
  logic  fwd_hit;

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_rd_r;
  logic              s1_we_r;
  logic              s1_xor_r;
  logic              s1_zero_r;
  logic [AW-1:0]     s1_addr_r;
  logic [BYTE_W-1:0] s1_data_r;
  snap_t             s1_snap_r;
  logic              fwd_r;
  logic [BYTE_W-1:0] fwd_data_r;

  logic [BYTE_W-1:0] mem_rdata_r;
  logic [BYTE_W-1:0] old_byte;
  logic [BYTE_W-1:0] wr_byte;
  logic [AW-1:0]     in_addr;

  logic              out_valid_r, out_valid_nxt;
  snap_t             out_snap_r;
  logic [BYTE_W-1:0] out_byte_r;

  assign item.func           = in_ch.func;
  assign item.seqnum_base    = in_ch.seqnum_base;
  assign item.version        = in_ch.version;
  assign item.pad_bit        = in_ch.pad_bit;
  assign item.ext_bit        = in_ch.ext_bit;
  assign item.csrc_count     = in_ch.csrc_count;
  assign item.marker         = in_ch.marker;
  assign item.payload_type   = in_ch.payload_type;
  assign item.timestamp      = in_ch.timestamp;
  assign item.payload_length = in_ch.payload_length;
  assign item.byte_index     = in_ch.byte_index;
  assign item.data_byte      = in_ch.data_byte;

  assign in_addr = in_ch.byte_index[AW-1:0];

  fxra_state #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (item),
    .dec       (dec),
    .snap      (snap)
  );

  fxra_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (BYTE_W)
  ) u_ram (
    .clk     (clk),
    .we      (s1_valid_r && s1_we_r),
    .waddr   (s1_addr_r),
    .wdata   (wr_byte),
    .re      (accept),
    .raddr   (in_addr),
    .rdata_r (mem_rdata_r)
  );

  assign s1_adv   = s1_valid_r && (!s1_rd_r || !out_valid_r || out_ch.ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_ch.ready = in_ready;
  assign accept   = in_ch.valid && in_ready;
  assign need_s1  = (in_ch.func == FUNC_READ) || dec.we;
  assign fwd_hit  = s1_valid_r && s1_we_r && (s1_addr_r == in_addr);

  assign old_byte = fwd_r ? fwd_data_r : mem_rdata_r;
  assign wr_byte  = s1_xor_r ? (old_byte ^ s1_data_r) : s1_data_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = need_s1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_rd_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rd_r    <= (in_ch.func == FUNC_READ);
      s1_we_r    <= dec.we;
      s1_xor_r   <= dec.xor_en;
      s1_zero_r  <= dec.rd_zero;
      s1_addr_r  <= in_addr;
      s1_data_r  <= in_ch.data_byte;
      s1_snap_r  <= snap;
      fwd_r      <= fwd_hit;
      fwd_data_r <= wr_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_rd_r) begin
      out_snap_r <= s1_snap_r;
      out_byte_r <= s1_zero_r ? '0 : old_byte;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.header_xor    = out_snap_r.header_xor;
  assign out_ch.timestamp_xor = out_snap_r.timestamp_xor;
  assign out_ch.length_xor    = out_snap_r.length_xor;
  assign out_ch.base_out      = out_snap_r.base_out;
  assign out_ch.columns_out   = out_snap_r.columns_out;
  assign out_ch.rows_out      = out_snap_r.rows_out;
  assign out_ch.repair_length = out_snap_r.repair_length;
  assign out_ch.repair_byte   = out_byte_r;

  `FXRA_ASSERT_NXT(a_fwd_capture, accept && fwd_hit, fwd_r)
  `FXRA_ASSERT_IMP(a_read_blocks, s1_valid_r && s1_rd_r && out_valid_r && !out_ch.ready, !in_ready)
  `FXRA_ASSERT_NXT(a_read_enters_s1, accept && (in_ch.func == FUNC_READ), s1_valid_r && s1_rd_r)
  `FXRA_ASSERT_IMP(a_write_not_read, s1_valid_r && s1_we_r, !s1_rd_r)

endmodule

// ===== bench/tb.sv =====
// testbench for the xor parity repair accumulator: queue-fed driver, shadow accumulator, checker
`timescale 1ns / 1ps
module tb;
  import fxra_pkg::*;

  localparam int MAX_P = MAX_PAYLOAD_DEF;

  typedef struct packed {
    snap_t             acc;
    logic [BYTE_W-1:0] repair_byte;
  } read_rec_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  fxra_in_if in_ch ();
  fxra_out_if out_ch ();

  fec_xor_repair_accumulator_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #2 clk = ~clk;

  item_t item_backlog[$];
  read_rec_t pending_reads[$];
  int pushed = 0;
  int errors = 0;

  // shadow copy of the accumulator
  logic [HDR_W-1:0] hdr_fold;
  logic [TS_W-1:0] ts_fold;
  logic [LEN_W-1:0] len_fold;
  logic [SEQ_W-1:0] seq_base;
  int rep_len;
  int prev_len;
  int src_len;
  logic [BYTE_W-1:0] rep_store [MAX_P];
  logic written_map [MAX_P];
  logic [CFG_W-1:0] columns_cfg;
  logic [CFG_W-1:0] rows_cfg;

  task automatic flag(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) flag($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task automatic fold_item(item_t it);
    logic [HDR_W-1:0] hw;
    int l;
    read_rec_t rec;
    case (it.func)
      FUNC_RESTART: begin
        hdr_fold = '0;
        ts_fold = '0;
        len_fold = '0;
        seq_base = it.seqnum_base;
        rep_len = 0;
        prev_len = 0;
        src_len = 0;
      end
      FUNC_HEADER: begin
        hw = {it.marker, it.payload_type, it.version, it.pad_bit, it.ext_bit, it.csrc_count};
        hdr_fold ^= hw;
        ts_fold ^= it.timestamp;
        len_fold ^= it.payload_length;
        l = it.payload_length;
        if (l > MAX_P) l = MAX_P;
        prev_len = rep_len;
        src_len = l;
        if (l > rep_len) rep_len = l;
      end
      FUNC_ADD: begin
        if (it.byte_index < src_len && it.byte_index < MAX_P) begin
          if (it.byte_index < prev_len) rep_store[it.byte_index] ^= it.data_byte;
          else rep_store[it.byte_index] = it.data_byte;
          written_map[it.byte_index] = 1'b1;
        end
      end
      default: begin
        rec.acc.header_xor = hdr_fold;
        rec.acc.timestamp_xor = ts_fold;
        rec.acc.length_xor = len_fold;
        rec.acc.base_out = seq_base;
        rec.acc.columns_out = columns_cfg;
        rec.acc.rows_out = rows_cfg;
        rec.acc.repair_length = LEN_W'(rep_len);
        rec.repair_byte = (it.byte_index < rep_len && it.byte_index < MAX_P) ?
                          rep_store[it.byte_index] : '0;
        pending_reads.push_back(rec);
      end
    endcase
  endtask

  // steer a read away from store entries that were never written
  function automatic logic [IDX_W-1:0] safe_index(logic [IDX_W-1:0] idx);
    int k;
    if (int'(idx) >= rep_len || written_map[idx]) return idx;
    k = int'(idx);
    while (k > 0 && !written_map[k]) k--;
    return IDX_W'(k);
  endfunction

  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic item_t noise();
    item_t it;
    it.func = func_t'($urandom_range(0, 3));
    it.seqnum_base = SEQ_W'($urandom);
    it.version = 2'($urandom);
    it.pad_bit = 1'($urandom);
    it.ext_bit = 1'($urandom);
    it.csrc_count = 4'($urandom);
    it.marker = 1'($urandom);
    it.payload_type = 7'($urandom);
    it.timestamp = $urandom;
    it.payload_length = LEN_W'($urandom);
    it.byte_index = IDX_W'($urandom);
    it.data_byte = BYTE_W'($urandom);
    return it;
  endfunction

  function automatic item_t op(func_t f);
    item_t it;
    it = noise();
    it.func = f;
    return it;
  endfunction

  function automatic item_t read_at(int glen);
    item_t it;
    int r;
    it = op(FUNC_READ);
    r = $urandom_range(0, 99);
    if (r < 70 && glen > 0) it.byte_index = IDX_W'($urandom_range(0, glen - 1));
    else if (r < 85 && glen < MAX_P) it.byte_index = IDX_W'(glen);
    return it;
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return LEN_W'($urandom_range(0, 40));
    if (r < 85) return LEN_W'($urandom_range(41, 300));
    if (r < 93) return LEN_W'($urandom_range(0, 1));
    if (r < 97) return LEN_W'($urandom_range(MAX_P - 1, MAX_P));
    return LEN_W'($urandom_range(MAX_P + 1, 4095));
  endfunction

  task automatic push_item(item_t it);
    item_backlog.push_back(it);
    pushed++;
  endtask

  // one protection group: restart, a few source packets with their bytes, reads
  task automatic gen_group();
    item_t it;
    int glen;
    int clip;
    int nb;
    int nh;
    push_item(op(FUNC_RESTART));
    glen = 0;
    nh = $urandom_range(1, 4);
    for (int h = 0; h < nh; h++) begin
      it = op(FUNC_HEADER);
      it.payload_length = pick_len();
      push_item(it);
      clip = (it.payload_length > MAX_P) ? MAX_P : it.payload_length;
      if (clip > glen) glen = clip;
      nb = (clip < 48) ? clip : 48;
      for (int i = 0; i < nb; i++) begin
        if ($urandom_range(0, 15) != 0) begin
          it = op(FUNC_ADD);
          it.byte_index = IDX_W'(i);
          push_item(it);
        end
      end
      if (clip > 48) begin
        repeat (6) begin
          it = op(FUNC_ADD);
          it.byte_index = IDX_W'($urandom_range(48, clip - 1));
          push_item(it);
        end
      end
      if (clip < MAX_P && $urandom_range(0, 3) == 0) begin
        it = op(FUNC_ADD);
        it.byte_index = IDX_W'($urandom_range(clip, MAX_P - 1));
        push_item(it);
      end
      if ($urandom_range(0, 9) == 0) push_item(noise());
      repeat ($urandom_range(0, 2)) push_item(read_at(glen));
    end
    repeat ($urandom_range(1, 3)) push_item(read_at(glen));
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (item_backlog.size() != 0 || in_ch.valid || pending_reads.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == CFG_COLUMNS) columns_cfg = val;
    else rows_cfg = val;
    cfg_we <= 1'b0;
  endtask

  // driver
  item_t cur;
  int in_gap = 0;
  int in_burst = 0;

  always @(posedge clk) begin
    logic fire;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      fire = in_ch.valid && in_ch.ready;
      if (fire) fold_item(cur);
      if (fire || !in_ch.valid) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (item_backlog.size() != 0) begin
          cur = item_backlog.pop_front();
          if (cur.func == FUNC_READ) cur.byte_index = safe_index(cur.byte_index);
          in_ch.func <= cur.func;
          in_ch.seqnum_base <= cur.seqnum_base;
          in_ch.version <= cur.version;
          in_ch.pad_bit <= cur.pad_bit;
          in_ch.ext_bit <= cur.ext_bit;
          in_ch.csrc_count <= cur.csrc_count;
          in_ch.marker <= cur.marker;
          in_ch.payload_type <= cur.payload_type;
          in_ch.timestamp <= cur.timestamp;
          in_ch.payload_length <= cur.payload_length;
          in_ch.byte_index <= cur.byte_index;
          in_ch.data_byte <= cur.data_byte;
          in_ch.valid <= 1'b1;
          in_gap = pick_gap(in_burst);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int out_stall = 0;
  int out_burst = 0;

  always @(posedge clk) begin
    read_rec_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_reads.size() == 0) begin
        flag("result transaction with no read pending");
      end else begin
        want = pending_reads.pop_front();
        check_field("header_xor", out_ch.header_xor, want.acc.header_xor);
        check_field("timestamp_xor", out_ch.timestamp_xor, want.acc.timestamp_xor);
        check_field("length_xor", out_ch.length_xor, want.acc.length_xor);
        check_field("base_out", out_ch.base_out, want.acc.base_out);
        check_field("columns_out", out_ch.columns_out, want.acc.columns_out);
        check_field("rows_out", out_ch.rows_out, want.acc.rows_out);
        check_field("repair_length", out_ch.repair_length, want.acc.repair_length);
        check_field("repair_byte", out_ch.repair_byte, want.repair_byte);
      end
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_ch.ready <= 1'b0;
      out_stall--;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 99) < 20) out_stall = pick_gap(out_burst);
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    item_t it;
    int start;
    logic [CFG_W-1:0] c;
    logic [CFG_W-1:0] r;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_COLUMNS;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_RESTART;
    in_ch.seqnum_base = '0;
    in_ch.version = '0;
    in_ch.pad_bit = 1'b0;
    in_ch.ext_bit = 1'b0;
    in_ch.csrc_count = '0;
    in_ch.marker = 1'b0;
    in_ch.payload_type = '0;
    in_ch.timestamp = '0;
    in_ch.payload_length = '0;
    in_ch.byte_index = '0;
    in_ch.data_byte = '0;
    out_ch.ready = 1'b0;
    hdr_fold = '0;
    ts_fold = '0;
    len_fold = '0;
    seq_base = '0;
    rep_len = 0;
    prev_len = 0;
    src_len = 0;
    columns_cfg = CFG_RESET;
    rows_cfg = CFG_RESET;
    for (int i = 0; i < MAX_P; i++) begin
      rep_store[i] = '0;
      written_map[i] = 1'b0;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty repair payload reads zero
    it = op(FUNC_READ); it.byte_index = '0; push_item(it);
    it = op(FUNC_RESTART); it.seqnum_base = '1; push_item(it);
    // byte before any header is dropped
    it = op(FUNC_ADD); it.byte_index = '0; push_item(it);
    it = op(FUNC_HEADER);
    it.version = '1; it.pad_bit = 1'b1; it.ext_bit = 1'b1; it.csrc_count = '1;
    it.marker = 1'b1; it.payload_type = '1; it.timestamp = '1;
    it.payload_length = LEN_W'(1);
    push_item(it);
    it = op(FUNC_ADD); it.byte_index = '0; it.data_byte = '1; push_item(it);
    it = op(FUNC_READ); it.byte_index = '0; push_item(it);
    it = op(FUNC_HEADER);
    it.version = '0; it.pad_bit = 1'b0; it.ext_bit = 1'b0; it.csrc_count = '0;
    it.marker = 1'b0; it.payload_type = '0; it.timestamp = '0;
    it.payload_length = LEN_W'(MAX_P);
    push_item(it);
    it = op(FUNC_ADD); it.byte_index = '1; it.data_byte = '1; push_item(it);
    it = op(FUNC_ADD); it.byte_index = '0; it.data_byte = '0; push_item(it);
    it = op(FUNC_READ); it.byte_index = '1; push_item(it);
    it = op(FUNC_READ); it.byte_index = '0; push_item(it);
    it = op(FUNC_HEADER); it.payload_length = '0; push_item(it);
    // byte past the source length is dropped
    it = op(FUNC_ADD); it.byte_index = '0; push_item(it);
    it = op(FUNC_READ); it.byte_index = '0; push_item(it);
    // overlong source saturates the repair length
    it = op(FUNC_HEADER); it.payload_length = '1; push_item(it);
    it = op(FUNC_ADD); it.byte_index = '1; it.data_byte = 8'hA5; push_item(it);
    it = op(FUNC_READ); it.byte_index = '1; push_item(it);
    it = op(FUNC_RESTART); it.seqnum_base = '0; push_item(it);
    // store kept but past the repair length
    it = op(FUNC_READ); it.byte_index = '0; push_item(it);
    it = op(FUNC_HEADER); it.payload_length = LEN_W'(1); push_item(it);
    it = op(FUNC_ADD); it.byte_index = '0; it.data_byte = 8'h3C; push_item(it);
    it = op(FUNC_ADD); it.byte_index = IDX_W'(1); push_item(it);
    it = op(FUNC_READ); it.byte_index = '0; push_item(it);
    it = op(FUNC_READ); it.byte_index = IDX_W'(1); push_item(it);
    it = op(FUNC_HEADER); it.payload_length = LEN_W'(3); push_item(it);
    it = op(FUNC_ADD); it.byte_index = '0; push_item(it);
    it = op(FUNC_ADD); it.byte_index = IDX_W'(2); push_item(it);
    it = op(FUNC_READ); it.byte_index = '0; push_item(it);
    it = op(FUNC_READ); it.byte_index = IDX_W'(2); push_item(it);
    it = op(FUNC_READ); it.byte_index = IDX_W'(3); push_item(it);

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin c = '0; r = '0; end
        1: begin c = '1; r = '1; end
        2: begin c = '0; r = '1; end
        3: begin c = '1; r = '0; end
        default: begin c = CFG_W'($urandom); r = CFG_W'($urandom); end
      endcase
      wait_idle();
      write_cfg(CFG_COLUMNS, c);
      write_cfg(CFG_ROWS, r);
      start = pushed;
      while (pushed - start < 100) gen_group();
    end

    wait_idle();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
